@@ sv/ussid_pkg.sv @@
// ============================================================================
// ussid_pkg: shared types and constants for the unique station/name table
// Holds the table geometry, the search key layout, the token that walks the
// cell chain and the result status codes.
// ============================================================================
package ussid_pkg;

    // Table geometry
    localparam int TABLE_DEPTH    = 64;
    localparam int IDX_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);

    // Item field widths
    localparam int ADDR_W         = 48;
    localparam int LEN_W          = 6;
    localparam int WORD_W         = 64;
    localparam int NAME_WORDS     = 4;
    localparam int NAME_W         = WORD_W * NAME_WORDS;
    localparam int MAX_NAME_BYTES = NAME_W / 8;

    // Result field widths
    localparam int STATUS_W       = 3;
    localparam int OUT_IDX_W      = 6;
    localparam int OUT_CNT_W      = 7;

    // Command codes carried in tuser
    localparam logic CMD_INSERT   = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SKIPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd4;

    // Search key: name bytes beyond the length are already zero, byte 0 on top.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [NAME_W-1:0] name;
    } key_t;

    // Token handed from cell to cell during a search.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] index;
    } token_t;

endpackage

@@ sv/ussid_cell.sv @@
// ============================================================================
// ussid_cell: one table entry with its compare stage
// Stores one (address, length, name) entry and passes the search token on to
// the next cell, marking it with this cell's index on the first match.
// ============================================================================
module ussid_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [ussid_pkg::IDX_W-1:0] cell_index,
    input  ussid_pkg::key_t        key,
    input  logic [ussid_pkg::CNT_W-1:0] count,
    input  logic                   wr_en,
    input  logic [ussid_pkg::IDX_W-1:0] wr_index,
    input  ussid_pkg::token_t      tok_in,
    output ussid_pkg::token_t      tok_out
);
    import ussid_pkg::*;

    key_t   entry_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   occupied;
    logic   hit;

    // The entry counts only while it lies below the fill count.
    assign occupied = CNT_W'(cell_index) < count;
    assign hit      = occupied && (entry_reg == key);

    // Claim the token on the first matching entry in index order.
    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && hit) begin
            tok_next.found = 1'b1;
            tok_next.index = cell_index;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // Entry storage, written only when a new pair is appended here.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_index == cell_index)) begin
            entry_reg <= key;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ sv/unique_station_ssid_table.sv @@
// ============================================================================
// unique_station_ssid_table: table of unique (station address, name) pairs
// Searches a chain of entry cells for the incoming pair, appends it when new,
// and returns one status transfer for every insert or clear command.
// ============================================================================
// Search: an insert with a name waits for the token to walk once through the
// chain of TABLE_DEPTH cells; a clear or an empty name skips the search.
// A new item is taken only once the result of the last one is registered.
// Reset: aresetn (synchronous, active low) empties the table and idles the
// handshakes; stored entries are not cleared and are ignored above the count.
module unique_station_ssid_table (
    input  logic         aclk,
    input  logic         aresetn,
    // Input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: station_addr[47:0], name_length[53:48], name_word0[117:54],
    //        name_word1[181:118], name_word2[245:182], name_word3[309:246]
    input  logic [311:0] s_tdata,
    // tuser: cmd[0]
    input  logic         s_tuser,
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0], entry_index[8:3], entry_count[15:9]
    output logic [15:0]  m_tdata
);
    import ussid_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    key_t             key_reg;
    key_t             key_in;
    logic             clear_reg;
    logic             start_reg;
    logic             found_reg;
    logic [IDX_W-1:0] fidx_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic [15:0]      m_data_reg;

    logic             s_xfer;
    logic             out_free;
    logic             finish_load;
    logic             add_entry;
    logic [STATUS_W-1:0]  res_status;
    logic [OUT_IDX_W-1:0] res_index;
    logic [LEN_W-1:0]     raw_len;
    logic [LEN_W-1:0]     clamped_len;
    logic [NAME_W-1:0]    raw_name;
    logic [NAME_W-1:0]    masked_name;
    logic [TABLE_DEPTH-1:0] tok_valid;

    token_t tok [TABLE_DEPTH+1];

    assign s_tready    = (state_reg == S_IDLE);
    assign s_xfer      = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign finish_load = (state_reg == S_FINISH) && out_free;

    // Clamp the length and zero the name bytes that lie beyond it.
    assign raw_len     = s_tdata[53:48];
    assign clamped_len = (raw_len > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES)
                                                            : raw_len;
    assign raw_name    = {s_tdata[117:54], s_tdata[181:118],
                          s_tdata[245:182], s_tdata[309:246]};

    always_comb begin
        for (int b = 0; b < MAX_NAME_BYTES; b++) begin
            masked_name[NAME_W-1-8*b -: 8] =
                (LEN_W'(b) < clamped_len) ? raw_name[NAME_W-1-8*b -: 8] : 8'h00;
        end
    end

    always_comb begin
        key_in.addr = s_tdata[ADDR_W-1:0];
        key_in.len  = clamped_len;
        key_in.name = masked_name;
    end

    // Chain of entry cells; the token enters at cell zero.
    assign tok[0] = '{valid: start_reg, found: 1'b0, index: '0};

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ussid_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (IDX_W'(i)),
            .key        (key_reg),
            .count      (count_reg),
            .wr_en      (add_entry),
            .wr_index   (IDX_W'(count_reg)),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
        assign tok_valid[i] = tok[i+1].valid;
    end

    // Result decision once the search is over and the output slot is free.
    always_comb begin
        res_status = STATUS_FULL;
        res_index  = '0;
        count_next = count_reg;
        add_entry  = 1'b0;
        if (clear_reg) begin
            res_status = STATUS_CLEARED;
            count_next = '0;
        end else if (key_reg.len == '0) begin
            res_status = STATUS_SKIPPED;
        end else if (found_reg) begin
            res_status = STATUS_DUPLICATE;
            res_index  = OUT_IDX_W'(fidx_reg);
        end else if (count_reg < CNT_W'(TABLE_DEPTH)) begin
            res_status = STATUS_ADDED;
            res_index  = OUT_IDX_W'(count_reg);
            count_next = count_reg + CNT_W'(1);
            add_entry  = finish_load;
        end
    end

    // Control sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == CMD_CLEAR || clamped_len == '0) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (tok[TABLE_DEPTH].valid) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_xfer && (s_tuser == CMD_INSERT) && (clamped_len != '0);
            if (finish_load) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            key_reg   <= key_in;
            clear_reg <= s_tuser;
            found_reg <= 1'b0;
        end
        if (state_reg == S_SEARCH && tok[TABLE_DEPTH].valid) begin
            found_reg <= tok[TABLE_DEPTH].found;
            fidx_reg  <= tok[TABLE_DEPTH].index;
        end
        if (finish_load) begin
            m_data_reg <= {OUT_CNT_W'(count_next), res_index, res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A match reported by the chain always points into the filled part.
    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok[TABLE_DEPTH].valid && tok[TABLE_DEPTH].found)
            |-> (CNT_W'(tok[TABLE_DEPTH].index) < count_reg))
        else $error("matched index beyond entry count");

    // The fill count never exceeds the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // No token is in flight while the block waits for a new item.
    a_chain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (tok_valid == '0))
        else $error("search token in flight while idle");

    // An append grows the count by exactly one.
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        add_entry |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not advance the entry count");

endmodule

@@ tb/unique_station_ssid_table_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// unique_station_ssid_table_tb: self-checking bench for the station/name table
// Drives insert and clear transfers with random gaps, predicts the status,
// index and count of every result from its own copy of the table, and checks
// each result transfer in order against the oldest prediction.
// ============================================================================
module unique_station_ssid_table_tb;
    import ussid_pkg::*;

    // One predicted or observed result transfer.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_IDX_W-1:0] index;
        logic [OUT_CNT_W-1:0] count;
    } table_result_t;

    // Keeps the first len name bytes (byte 0 sits in the top bits).
    function automatic logic [NAME_W-1:0] name_mask(int unsigned len);
        logic [NAME_W-1:0] m;
        m = '1;
        if (len == 0)
            m = '0;
        else
            m = m << (NAME_W - 8 * len);
        return m;
    endfunction

    // Scoreboard: mirrors the pair table and holds the results still to come.
    class ssid_table_scoreboard;
        key_t            stored_keys[TABLE_DEPTH];
        int unsigned     used_count;
        table_result_t   expected_results[$];
        int unsigned     failures;

        function new();
            used_count = 0;
            failures   = 0;
        endfunction

        function int unsigned entries();
            return used_count;
        endfunction

        function key_t entry(int unsigned i);
            return stored_keys[i];
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Applies one accepted input transfer to the table copy.
        function void note_transfer(logic cmd, logic [ADDR_W-1:0] addr,
                                    logic [LEN_W-1:0] len, logic [NAME_W-1:0] name);
            table_result_t r;
            key_t          probe;
            bit            found;
            int unsigned   clipped;
            r.status = STATUS_FULL;
            r.index  = '0;
            if (cmd == CMD_CLEAR) begin
                used_count = 0;
                r.status   = STATUS_CLEARED;
            end else begin
                // Overlong lengths compare and store as the full name.
                clipped = (len > LEN_W'(MAX_NAME_BYTES)) ? MAX_NAME_BYTES : 32'(len);
                if (clipped == 0) begin
                    r.status = STATUS_SKIPPED;
                end else begin
                    probe.addr = addr;
                    probe.len  = LEN_W'(clipped);
                    probe.name = name & name_mask(clipped);
                    found = 1'b0;
                    for (int i = 0; i < used_count && !found; i++) begin
                        if (stored_keys[i] == probe) begin
                            found    = 1'b1;
                            r.status = STATUS_DUPLICATE;
                            r.index  = OUT_IDX_W'(i);
                        end
                    end
                    if (!found && used_count < TABLE_DEPTH) begin
                        stored_keys[used_count] = probe;
                        r.index    = OUT_IDX_W'(used_count);
                        used_count = used_count + 1;
                        r.status   = STATUS_ADDED;
                    end
                end
            end
            r.count = OUT_CNT_W'(used_count);
            expected_results.push_back(r);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(logic [15:0] data);
            table_result_t got;
            table_result_t want;
            got.status = data[2:0];
            got.index  = data[8:3];
            got.count  = data[15:9];
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result with nothing pending: status %0d index %0d count %0d",
                             got.status, got.index, got.count);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.count !== want.count) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: expected status %0d index %0d count %0d, got %0d %0d %0d",
                             want.status, want.index, want.count,
                             got.status, got.index, got.count);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1320;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [311:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;

    ssid_table_scoreboard sb;
    int  items_sent;
    int  idle_cycles;
    int  hold_cycles;
    int  hold_requests;
    bit  no_idle;

    unique_station_ssid_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ADDR_W-1:0];
    endfunction

    function automatic logic [NAME_W-1:0] random_name();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Offers one item after a random gap and waits for its transfer.
    // The valid stays high afterwards; the next call or idle_input moves it.
    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic [NAME_W-1:0] name);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, name[63:0], name[127:64], name[191:128], name[255:192],
                     len, addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_transfer(cmd, addr, len, name);
        items_sent++;
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Holds the input back until every predicted result has arrived.
    task automatic wait_drained();
        idle_input();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_clear();
        send_item(CMD_CLEAR, random_addr(), LEN_W'($urandom_range(0, 63)), random_name());
    endtask

    // New pair with random content; a tenth use an overlong length.
    task automatic send_fresh();
        logic [LEN_W-1:0] len;
        len = LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                 : $urandom_range(1, 32));
        send_item(CMD_INSERT, random_addr(), len, random_name());
    endtask

    // Stored pair again, with junk beyond its length.
    task automatic send_repeat();
        key_t             k;
        logic [LEN_W-1:0] len;
        if (sb.entries() == 0) begin
            send_fresh();
        end else begin
            k   = sb.entry($urandom_range(0, sb.entries() - 1));
            len = k.len;
            if (len == MAX_NAME_BYTES && $urandom_range(0, 1) == 1)
                len = LEN_W'($urandom_range(32, 63));
            send_item(CMD_INSERT, k.addr, len,
                      k.name | (random_name() & ~name_mask(32'(k.len))));
        end
    endtask

    // Stored pair with one bit of address or name changed, or a new length.
    task automatic send_near_miss();
        key_t              k;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [NAME_W-1:0] name;
        if (sb.entries() == 0) begin
            send_fresh();
        end else begin
            k    = sb.entry($urandom_range(0, sb.entries() - 1));
            addr = k.addr;
            len  = k.len;
            name = k.name | (random_name() & ~name_mask(32'(k.len)));
            case ($urandom_range(0, 2))
                0: begin
                    addr = addr ^ (48'h1 << $urandom_range(0, ADDR_W - 1));
                end
                1: begin
                    name = name ^ ({{(NAME_W-1){1'b0}}, 1'b1} <<
                                   (NAME_W - 1 - $urandom_range(0, 8 * len - 1)));
                end
                default: begin
                    len = LEN_W'($urandom_range(1, 32));
                end
            endcase
            send_item(CMD_INSERT, addr, len, name);
        end
    endtask

    // Result side: random stalls, an occasional long hold-off, then a check.
    initial begin
        int gap;
        int holds_served;
        holds_served = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (holds_served != hold_requests) begin
                gap          = hold_cycles;
                holds_served = hold_requests;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("unique_station_ssid_table verification failed");
            $finish;
        end
    end

    // Stimulus: reset, directed cases, a table fill, then random segments.
    initial begin
        int          seg_items;
        int          pick;
        logic [NAME_W-1:0] ones;
        sb            = new();
        ones          = '1;
        items_sent    = 0;
        hold_cycles   = 0;
        hold_requests = 0;
        no_idle       = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_INSERT;
        m_tready      = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty name, shortest and full names, bytes beyond the length ignored.
        send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 6'd0, ones);
        send_item(CMD_INSERT, 48'h0, 6'd1, ones);
        send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 6'd32, ones);
        send_item(CMD_INSERT, 48'h0, 6'd1, {8'hFF, 248'h0});
        // Overlong length matches the full-length entry.
        send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 6'd63, ones);
        // Last byte, address bit and length differ from stored pairs.
        send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 6'd32, ones ^ 256'h1);
        send_item(CMD_INSERT, 48'h1, 6'd1, ones);
        send_item(CMD_INSERT, 48'h0, 6'd2, ones);
        send_item(CMD_INSERT, 48'h0, 6'd8, '0);
        send_item(CMD_INSERT, 48'h0, 6'd8, {64'h0, ones[191:0]});
        send_item(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 6'd33, ones ^ (ones << 255));
        send_item(CMD_INSERT, 48'h8000_0000_0000, 6'd16, random_name());
        send_item(CMD_INSERT, random_addr(), 6'd0, random_name());
        send_clear();
        send_item(CMD_INSERT, 48'h0, 6'd1, ones);
        send_item(CMD_INSERT, 48'h0, 6'd1, ones);
        send_clear();

        // Fill the table past its depth while the result side holds off.
        hold_cycles = 300;
        hold_requests++;
        repeat (TABLE_DEPTH + 3) send_fresh();
        repeat (6) send_repeat();
        repeat (2) send_near_miss();
        wait_drained();
        send_clear();

        // Random segments of mostly well-formed traffic.
        while (items_sent < ITEM_TARGET) begin
            seg_items = $urandom_range(20, 150);
            no_idle   = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) begin
                hold_cycles = $urandom_range(100, 300);
                hold_requests++;
            end
            if ($urandom_range(0, 2) == 0)
                send_clear();
            repeat (seg_items) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    send_clear();
                else if (pick < 10)
                    send_item(CMD_INSERT, random_addr(), 6'd0, random_name());
                else if (pick < 45)
                    send_repeat();
                else if (pick < 60)
                    send_near_miss();
                else
                    send_fresh();
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        // Drain, then allow one more search time for stray results.
        no_idle = 1'b0;
        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("unique_station_ssid_table verification clean");
        else
            $display("unique_station_ssid_table verification failed");
        $finish;
    end

endmodule
